// ===== sv/bed_pkg.sv =====
// Shared types, sizes and helper functions for the bit extract/deposit block.
`timescale 1ns / 1ps

package bed_pkg;

  // Width of the working word inside the network
  localparam int unsigned WORD_WIDTH = 32;
  // One network stage for each power-of-two shift below WORD_WIDTH
  localparam int unsigned STAGES     = $clog2(WORD_WIDTH);
  // Fixed width of the data ports
  localparam int unsigned PORT_WIDTH = 32;

  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef enum logic {
    OP_EXTRACT = 1'b0,
    OP_DEPOSIT = 1'b1
  } op_e;

  // Transaction handed from the move generator to the deposit stages
  typedef struct packed {
    op_e                    op;
    word_t                  x;
    word_t                  mask;
    word_t [STAGES-1:0]     moves;
  } item_t;

  // Prefix XOR: bit n becomes the parity of bits 0..n
  function automatic word_t prefix_parity(word_t v);
    word_t r;
    r = v;
    for (int unsigned k = 1; k < WORD_WIDTH; k = k * 2) begin
      r = r ^ (r << k);
    end
    return r;
  endfunction

endpackage

// ===== sv/bed_gen.sv =====
// Move-mask generator pipeline; also applies the compress shifts for extract.
`timescale 1ns / 1ps

module bed_gen (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           operation_i,
  input  bed_pkg::word_t src_i,
  input  bed_pkg::word_t mask_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bed_pkg::item_t out_item_o
);
  import bed_pkg::*;

  typedef struct packed {
    op_e                op;
    word_t              x;
    word_t              m;
    word_t              zeros;
    word_t              mask;
    word_t [STAGES-1:0] moves;
  } gen_t;

  gen_t               st_q [STAGES];
  gen_t               st_d [STAGES];
  gen_t               st_in [STAGES];
  logic [STAGES-1:0]  valid_q;
  logic [STAGES-1:0]  valid_in;
  logic [STAGES:0]    en;
  word_t              par [STAGES];
  word_t              mv [STAGES];
  word_t              tk [STAGES];
  gen_t               first;

  // Entry: zeros to the right of each position, extract pre-masks the source
  always_comb begin
    first       = '0;
    first.op    = op_e'(operation_i);
    first.mask  = mask_i;
    first.m     = mask_i;
    first.zeros = (~mask_i) << 1;
    first.x     = (op_e'(operation_i) == OP_DEPOSIT) ? src_i : (src_i & mask_i);
  end

  assign en[STAGES] = out_ready_i;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam int unsigned SH = 1 << g;

    // Stage may load when empty or when the next one moves on
    assign en[g] = !valid_q[g] || en[g+1];

    if (g == 0) begin : g_first
      assign st_in[g]    = first;
      assign valid_in[g] = in_valid_i;
    end else begin : g_rest
      assign st_in[g]    = st_q[g-1];
      assign valid_in[g] = valid_q[g-1];
    end

    // One move mask per stage; compress shift applied right away
    always_comb begin
      par[g]            = prefix_parity(st_in[g].zeros);
      mv[g]             = par[g] & st_in[g].m;
      tk[g]             = st_in[g].x & mv[g];
      st_d[g]           = st_in[g];
      st_d[g].m         = (st_in[g].m ^ mv[g]) | (mv[g] >> SH);
      st_d[g].zeros     = st_in[g].zeros & ~par[g];
      st_d[g].moves[g]  = mv[g];
      if (st_in[g].op == OP_EXTRACT) begin
        st_d[g].x = (st_in[g].x ^ tk[g]) | (tk[g] >> SH);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en[g]) begin
        valid_q[g] <= valid_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[g] && valid_in[g]) begin
        st_q[g] <= st_d[g];
      end
    end
  end

  assign in_ready_o       = en[0];
  assign out_valid_o      = valid_q[STAGES-1];
  assign out_item_o.op    = st_q[STAGES-1].op;
  assign out_item_o.x     = st_q[STAGES-1].x;
  assign out_item_o.mask  = st_q[STAGES-1].mask;
  assign out_item_o.moves = st_q[STAGES-1].moves;

  // Moving bits never changes how many are selected
  a_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[STAGES-1] |->
      $countones(st_q[STAGES-1].m) == $countones(st_q[STAGES-1].mask))
    else $error("selected bit count changed in move network");

  // Compressed value lies entirely inside the packed mask
  a_compress_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[STAGES-1] && st_q[STAGES-1].op == OP_EXTRACT) |->
      (st_q[STAGES-1].x & ~st_q[STAGES-1].m) == '0)
    else $error("extract result has bits outside the packed field");

  // Back-pressure only when every stage holds a transaction
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input stalled with an empty stage");

endmodule

// ===== sv/bed_dep.sv =====
// Deposit pipeline: applies the move masks in reverse order and drives the result.
`timescale 1ns / 1ps

module bed_dep (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bed_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bed_pkg::word_t result_o
);
  import bed_pkg::*;

  item_t              st_q [STAGES];
  item_t              st_d [STAGES];
  item_t              st_in [STAGES];
  logic [STAGES-1:0]  valid_q;
  logic [STAGES-1:0]  valid_in;
  logic [STAGES:0]    en;

  assign en[STAGES] = out_ready_i;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam int unsigned IDX = STAGES - 1 - g;
    localparam int unsigned SH  = 1 << IDX;

    assign en[g] = !valid_q[g] || en[g+1];

    if (g == 0) begin : g_first
      assign st_in[g]    = in_item_i;
      assign valid_in[g] = in_valid_i;
    end else begin : g_rest
      assign st_in[g]    = st_q[g-1];
      assign valid_in[g] = valid_q[g-1];
    end

    // Expand step; the last stage also clears bits outside the mask
    always_comb begin
      st_d[g] = st_in[g];
      if (st_in[g].op == OP_DEPOSIT) begin
        st_d[g].x = (st_in[g].x & ~st_in[g].moves[IDX]) |
                    ((st_in[g].x << SH) & st_in[g].moves[IDX]);
        if (g == STAGES - 1) begin
          st_d[g].x = st_d[g].x & st_in[g].mask;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[g] <= 1'b0;
      end else if (en[g]) begin
        valid_q[g] <= valid_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[g] && valid_in[g]) begin
        st_q[g] <= st_d[g];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[STAGES-1];
  assign result_o    = st_q[STAGES-1].x;

  // A held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(result_o)))
    else $error("pending result lost or changed");

  // Deposit output never sets a bit outside the mask
  a_dep_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[STAGES-1] && st_q[STAGES-1].op == OP_DEPOSIT) |->
      (st_q[STAGES-1].x & ~st_q[STAGES-1].mask) == '0)
    else $error("deposit result has bits outside the mask");

endmodule

// ===== sv/bit_extract_deposit.sv =====
// Top level of the parallel bit extract/deposit unit.
//
//   channel   direction   handshake               payload
//   input     in          in_valid_i/in_stall_o    operation_i, source_word_i, select_mask_i
//   output    out         out_valid_o/out_stall_i  result_word_o
//
// One transaction per cycle sustained while out_stall_i is low; the path runs through
// five move-mask stages (one prefix-XOR tree each) then five deposit stages.
// Every stage register holds its transaction until the next stage frees up, so
// bubbles close up and a stalled output does not block stages that are empty.
// in_stall_o rises only when all stages are full and the output is stalled.
// Reset clears all valid bits asynchronously; no clearing pass is needed.
`timescale 1ns / 1ps

module bit_extract_deposit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [bed_pkg::PORT_WIDTH-1:0] source_word_i,
  input  logic [bed_pkg::PORT_WIDTH-1:0] select_mask_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bed_pkg::PORT_WIDTH-1:0] result_word_o
);
  import bed_pkg::*;

  logic  gen_ready;
  logic  mid_valid;
  logic  mid_ready;
  item_t mid_item;
  word_t result;
  word_t src_w;
  word_t mask_w;

  // Fit port words to the network width
  assign src_w  = WORD_WIDTH'(source_word_i);
  assign mask_w = WORD_WIDTH'(select_mask_i);

  bed_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (gen_ready),
    .operation_i (operation_i),
    .src_i       (src_w),
    .mask_i      (mask_w),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_item_o  (mid_item)
  );

  bed_dep u_dep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_item_i   (mid_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .result_o    (result)
  );

  assign in_stall_o    = !gen_ready;
  assign result_word_o = PORT_WIDTH'(result);

endmodule

// ===== bench/tb_bit_extract_deposit.sv =====
// Self-checking testbench for the parallel bit extract/deposit unit.
`timescale 1ns / 1ps

module tb_bit_extract_deposit;
  import bed_pkg::*;

  localparam int unsigned PW           = PORT_WIDTH;
  // Pipeline depth plus margin, used for the final drain
  localparam int unsigned DRAIN_CYCLES = 2 * STAGES + 6;
  // Cycles without any transaction before the run is abandoned
  localparam int unsigned IDLE_LIMIT   = 2000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_RANDOM,
    IDLE_HEAVY
  } idle_mode_e;

  logic          clk         = 1'b0;
  logic          rst_n       = 1'b0;
  logic          in_valid    = 1'b0;
  logic          in_stall;
  logic          operation   = 1'b0;
  logic [PW-1:0] source_word = '0;
  logic [PW-1:0] select_mask = '0;
  logic          out_valid;
  logic          out_stall   = 1'b0;
  logic [PW-1:0] result_word;

  idle_mode_e    send_mode  = IDLE_RANDOM;
  idle_mode_e    stall_mode = IDLE_RANDOM;

  logic [PW-1:0] expected_results[$];
  int unsigned   items_sent      = 0;
  int unsigned   results_checked = 0;
  int unsigned   mismatch_count  = 0;
  int unsigned   idle_cycles     = 0;
  int unsigned   stall_left_q    = 0;

  bit_extract_deposit i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .source_word_i (source_word),
    .select_mask_i (select_mask),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .result_word_o (result_word)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap length: mostly zero or short, now and then long
  function automatic int unsigned gap_cycles(idle_mode_e mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_HEAVY: return (r < 30) ? 0 : ((r < 70) ? $urandom_range(1, 4) : $urandom_range(5, 30));
      default:    return (r < 60) ? 0 : ((r < 92) ? $urandom_range(1, 3) : $urandom_range(4, 20));
    endcase
  endfunction

  // Bit-serial gather/scatter: walk the mask upward, one selected bit per slot
  function automatic logic [PW-1:0] predict_result(op_e op, logic [PW-1:0] src,
                                                   logic [PW-1:0] mask);
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] r;
    int unsigned slot;
    s    = 64'(src);
    m    = 64'(mask);
    r    = '0;
    slot = 0;
    for (int unsigned pos = 0; pos < WORD_WIDTH && pos < 64; pos++) begin
      if (m[pos]) begin
        if (op == OP_EXTRACT) r[slot] = s[pos];
        else r[pos] = s[slot];
        slot++;
      end
    end
    return r[PW-1:0];
  endfunction

  // Output stall generator
  always @(posedge clk) begin : stall_gen
    int unsigned run;
    run = 0;
    if (stall_left_q > 0) begin
      stall_left_q <= stall_left_q - 1;
      out_stall    <= 1'b1;
    end else begin
      run = gap_cycles(stall_mode);
      out_stall    <= (run > 0);
      stall_left_q <= (run > 0) ? run - 1 : 0;
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    logic [PW-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, result_word);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_word !== want) begin
          $display("%0t ns: result_word mismatch, expected %h, actual %h",
                   $time, want, result_word);
          mismatch_count++;
        end
        results_checked++;
      end
    end
  end

  // Watchdog: abandon the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: watchdog expired, %0d results still expected",
                 $time, expected_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Send one transaction; called and returns on a rising edge
  task automatic send_item(input op_e op, input logic [PW-1:0] src,
                           input logic [PW-1:0] mask);
    int unsigned gap;
    gap = gap_cycles(send_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    source_word <= src;
    select_mask <= mask;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_result(op, src, mask));
    items_sent++;
  endtask

  // Random operands with masks of varied density and shape
  task automatic send_random_items(input int unsigned count);
    logic [PW-1:0] mask;
    int unsigned   lo;
    int unsigned   hi;
    for (int unsigned n = 0; n < count; n++) begin
      mask = $urandom();
      case ($urandom_range(0, 5))
        0: mask = mask & $urandom() & $urandom();
        1: mask = mask | $urandom() | $urandom();
        2: begin
          lo   = $urandom_range(0, PW - 1);
          hi   = $urandom_range(lo, PW - 1);
          mask = ({PW{1'b1}} >> (PW - 1 - hi)) & ({PW{1'b1}} << lo);
        end
        3: mask = 1 << $urandom_range(0, PW - 1);
        default: ;
      endcase
      send_item(op_e'($urandom_range(0, 1)), $urandom(), mask);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Corner operands under both operations, including the empty mask
  task automatic test_directed();
    logic [PW-1:0] srcs[10];
    logic [PW-1:0] masks[10];
    srcs  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_3C3D,
              32'hFFFF_FFFF, 32'h1234_5678, 32'h5555_5555, 32'hAAAA_AAAA, 32'hDEAD_BEEF};
    masks = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
              32'h8000_0000, 32'h8000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_0FF0};
    send_mode  = IDLE_RANDOM;
    stall_mode = IDLE_RANDOM;
    for (int k = 0; k < 10; k++) begin
      send_item(OP_EXTRACT, srcs[k], masks[k]);
      send_item(OP_DEPOSIT, srcs[k], masks[k]);
    end
  endtask

  // Full rate, no idling on either side
  task automatic test_back_to_back();
    send_mode  = IDLE_NONE;
    stall_mode = IDLE_NONE;
    send_random_items(200);
  endtask

  // Random gaps on both sides
  task automatic test_random_gaps();
    send_mode  = IDLE_RANDOM;
    stall_mode = IDLE_RANDOM;
    send_random_items(250);
  endtask

  // Sender holds off until the pipeline is empty, then resumes
  task automatic test_drain_pause();
    send_mode  = IDLE_RANDOM;
    stall_mode = IDLE_RANDOM;
    send_random_items(40);
    wait_for_results();
    send_random_items(40);
  endtask

  // Heavy output stall so the pipeline fills and pushes back on the input
  task automatic test_output_backpressure();
    send_mode  = IDLE_NONE;
    stall_mode = IDLE_HEAVY;
    send_random_items(150);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_back_to_back();
    test_random_gaps();
    test_drain_pause();
    test_output_backpressure();
    stall_mode = IDLE_RANDOM;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d extract/deposit transactions (corners, full rate, gaps, drain pause,",
             items_sent);
    $display("output backpressure); %0d results compared, %0d wrong.",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
